>>> design/pfd_pkg.sv
// package for the polar fm discriminator: payload types, cordic formats,
// arctangent table and fixed-point constants; no dependencies
`default_nettype none

package pfd_pkg;

  localparam int SampleBits = 16;
  localparam int GuardBits  = 8;
  localparam int RateBits   = 24;
  localparam int MagBits    = 16;
  localparam int FreqBits   = 24;

  // cordic datapath: guard bits plus headroom for the gain of about 1.65 * sqrt(2)
  localparam int CordW = SampleBits + GuardBits + 3;
  localparam int AccW  = 32;
  // unsigned magnitude times inverse gain
  localparam int ProdW = CordW - 1 + 24;

  localparam int                MaxStages   = 24;
  localparam int                DefStages   = 16;
  localparam int                DefPhase    = 16;
  localparam logic [RateBits-1:0] RateReset = 24'd48000;
  localparam logic [23:0]       InvGainQ24  = 24'd10188014;

  typedef struct packed {
    logic signed [SampleBits-1:0] in_real;
    logic signed [SampleBits-1:0] in_imag;
  } pfd_in_t;

  typedef struct packed {
    logic        [MagBits-1:0]  magnitude;
    logic signed [FreqBits-1:0] freq_hz;
  } pfd_out_t;

  typedef struct packed {
    logic signed [CordW-1:0] x;
    logic signed [CordW-1:0] y;
    logic        [AccW-1:0]  acc;
    logic                    zero;
  } pfd_cordic_t;

  // round(atan(2^-i) / (2 pi) * 2^32)
  localparam logic [AccW-1:0] AtanTurns [MaxStages] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
    32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
    32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
    32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
  };

  function automatic logic [AccW-1:0] pfd_atan(input logic [4:0] idx);
    logic [AccW-1:0] r;
    r = '0;
    if (idx < 5'(MaxStages)) begin
      r = AtanTurns[idx];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

>>> design/pfd_cordic_cell.sv
// one vectoring cordic iteration with its own pipeline register
// depends on pfd_pkg for the cell payload and the arctangent table
`default_nettype none

module pfd_cordic_cell
  import pfd_pkg::*;
#(
  parameter int Shift = 0
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        up_valid,
  input  wire pfd_cordic_t up_data,
  output logic             up_ready,
  output logic             dn_valid,
  output pfd_cordic_t      dn_data,
  input  wire logic        dn_ready
);

  localparam logic [4:0] Idx = 5'(Shift);

  logic signed [CordW-1:0] xs;
  logic signed [CordW-1:0] ys;
  pfd_cordic_t             cell_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    xs = up_data.x >>> Shift;
    ys = up_data.y >>> Shift;
    cell_next = up_data;
    // rotate toward the x axis
    if (!up_data.y[CordW-1]) begin
      cell_next.x   = up_data.x + ys;
      cell_next.y   = up_data.y - xs;
      cell_next.acc = up_data.acc + pfd_atan(Idx);
    end else begin
      cell_next.x   = up_data.x - ys;
      cell_next.y   = up_data.y + xs;
      cell_next.acc = up_data.acc - pfd_atan(Idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      dn_data <= cell_next;
    end
  end

endmodule

`default_nettype wire

>>> design/pfd_gain_stage.sv
// phase rounding and gain-correction multiply after the cordic chain
// depends on pfd_pkg for the cell payload and gain constant
`default_nettype none

module pfd_gain_stage
  import pfd_pkg::*;
#(
  parameter int PHASE_BITS = DefPhase
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              up_valid,
  input  wire pfd_cordic_t       up_data,
  output logic                   up_ready,
  output logic                   dn_valid,
  output logic [PHASE_BITS-1:0]  dn_phase,
  output logic [ProdW-1:0]       dn_prod,
  input  wire logic              dn_ready
);

  localparam logic [AccW-1:0] RoundBit = AccW'(1) << (31 - PHASE_BITS);

  logic [AccW-1:0]  acc_rnd;
  logic [CordW-2:0] xmag;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    acc_rnd = up_data.acc + RoundBit;
    xmag    = up_data.x[CordW-1] ? '0 : up_data.x[CordW-2:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
    if (up_ready && up_valid) begin
      // all-zero sample has phase and magnitude zero
      if (up_data.zero) begin
        dn_phase <= '0;
        dn_prod  <= '0;
      end else begin
        dn_phase <= acc_rnd[AccW-1 -: PHASE_BITS];
        dn_prod  <= ProdW'(xmag) * ProdW'(InvGainQ24);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/pfd_disc_stage.sv
// phase difference against the stored phase, magnitude rounding,
// frequency multiply and the output register; depends on pfd_pkg
`default_nettype none

module pfd_disc_stage
  import pfd_pkg::*;
#(
  parameter int PHASE_BITS = DefPhase
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [RateBits-1:0] rate,
  input  wire logic                up_valid,
  input  wire logic [PHASE_BITS-1:0] up_phase,
  input  wire logic [ProdW-1:0]    up_prod,
  output logic                     up_ready,
  output logic                     out_valid,
  output pfd_out_t                 out_data,
  input  wire logic                out_stall
);

  localparam int MagLsb = 24 + GuardBits;
  localparam logic [ProdW:0] RoundMag = (ProdW + 1)'(1) << (MagLsb - 1);

  logic [PHASE_BITS-1:0]         last_phase;
  logic signed [PHASE_BITS-1:0]  dphase;
  logic [MagBits-1:0]            mag;
  logic                          mid_valid;
  logic                          mid_ready;
  logic                          out_ready;
  logic [ProdW:0]                mag_sum;
  logic signed [PHASE_BITS+24:0] fprod;

  assign out_ready = !out_valid || !out_stall;
  assign mid_ready = !mid_valid || out_ready;
  assign up_ready  = mid_ready;

  always_comb begin
    mag_sum = {1'b0, up_prod} + RoundMag;
    fprod   = dphase * $signed({1'b0, rate});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid  <= 1'b0;
      out_valid  <= 1'b0;
      last_phase <= '0;
    end else begin
      if (mid_ready) begin
        mid_valid <= up_valid;
      end
      if (out_ready) begin
        out_valid <= mid_valid;
      end
      if (mid_ready && up_valid) begin
        last_phase <= up_phase;
      end
    end
    if (mid_ready && up_valid) begin
      // wraps to half a turn either way
      dphase <= up_phase - last_phase;
      if (|mag_sum[ProdW:MagLsb+MagBits]) begin
        mag <= '1;
      end else begin
        mag <= mag_sum[MagLsb+MagBits-1:MagLsb];
      end
    end
    if (out_ready && mid_valid) begin
      out_data.magnitude <= mag;
      // floor shift by the phase width
      out_data.freq_hz   <= fprod[PHASE_BITS+FreqBits-1:PHASE_BITS];
    end
  end

endmodule

`default_nettype wire

>>> design/polar_fm_discriminator_core.sv
// top level of the polar fm discriminator: input stage, cordic cell chain,
// gain stage and discriminator stage; depends on pfd_pkg and the pfd_* modules
//
//   port group | direction | payload    | handshake
//   in_*       | in        | pfd_in_t   | in_valid / in_stall
//   out_*      | out       | pfd_out_t  | out_valid / out_stall
//   cfg_*      | in        | 24-bit rate| cfg_we, no wait
//
// one sample per cycle sustained while out_stall is low, through a chain of CORDIC_STAGES cells;
// registers from transfer in to out_valid: input stage, cells, gain stage, disc middle and output.
// every stage has its own valid bit, so empty stages close up under a stall
// and in_stall rises only when every stage is full and out_stall is high.
// synchronous reset clears valid bits and the stored phase, rate back to 48000.
`default_nettype none

module polar_fm_discriminator_core
  import pfd_pkg::*;
#(
  parameter int PHASE_BITS    = DefPhase,
  parameter int CORDIC_STAGES = DefStages
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire pfd_in_t             in_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output pfd_out_t                 out_data,
  input  wire logic                cfg_we,
  input  wire logic [RateBits-1:0] cfg_data
);

  logic [RateBits-1:0]    rate;
  logic [CORDIC_STAGES:0] cv;
  logic [CORDIC_STAGES:0] cr;
  pfd_cordic_t            cd [CORDIC_STAGES+1];
  pfd_cordic_t            entry;
  logic                   g_valid;
  logic                   g_ready;
  logic [PHASE_BITS-1:0]  g_phase;
  logic [ProdW-1:0]       g_prod;
  logic                   tail_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rate <= RateReset;
    end else if (cfg_we) begin
      rate <= cfg_data;
    end
  end

  // scale by the guard bits, left half plane turned by half a turn
  always_comb begin
    entry.x    = CordW'(in_data.in_real) <<< GuardBits;
    entry.y    = CordW'(in_data.in_imag) <<< GuardBits;
    entry.acc  = '0;
    entry.zero = (in_data.in_real == '0) && (in_data.in_imag == '0);
    if (in_data.in_real[SampleBits-1]) begin
      entry.x   = -entry.x;
      entry.y   = -entry.y;
      entry.acc = AccW'(1) << (AccW - 1);
    end
  end

  assign cr[0]    = !cv[0] || cr[1];
  assign in_stall = !cr[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (cr[0]) begin
      cv[0] <= in_valid;
    end
    if (cr[0] && in_valid) begin
      cd[0] <= entry;
    end
  end

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    logic up_ready;
    pfd_cordic_cell #(
      .Shift(i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .up_valid(cv[i]),
      .up_data (cd[i]),
      .up_ready(up_ready),
      .dn_valid(cv[i+1]),
      .dn_data (cd[i+1]),
      .dn_ready(i == CORDIC_STAGES - 1 ? tail_ready : cr[i+2 > CORDIC_STAGES ? CORDIC_STAGES : i+2])
    );
    assign cr[i+1] = up_ready;
  end

  pfd_gain_stage #(
    .PHASE_BITS(PHASE_BITS)
  ) u_gain (
    .clk     (clk),
    .rst     (rst),
    .up_valid(cv[CORDIC_STAGES]),
    .up_data (cd[CORDIC_STAGES]),
    .up_ready(tail_ready),
    .dn_valid(g_valid),
    .dn_phase(g_phase),
    .dn_prod (g_prod),
    .dn_ready(g_ready)
  );

  pfd_disc_stage #(
    .PHASE_BITS(PHASE_BITS)
  ) u_disc (
    .clk      (clk),
    .rst      (rst),
    .rate     (rate),
    .up_valid (g_valid),
    .up_phase (g_phase),
    .up_prod  (g_prod),
    .up_ready (g_ready),
    .out_valid(out_valid),
    .out_data (out_data),
    .out_stall(out_stall)
  );

  logic signed [FreqBits:0] freq_ext;
  logic signed [FreqBits:0] half_hi;
  logic signed [FreqBits:0] half_lo;

  assign freq_ext = {out_data.freq_hz[FreqBits-1], out_data.freq_hz};
  assign half_hi  = $signed({2'b00, rate[RateBits-1:1]});
  assign half_lo  = -$signed({1'b0, (rate >> 1) + RateBits'(rate[0])});

  // the input side only backs up when the whole chain is full and held
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall && cv[0] && g_valid))
    else $error("input stalled with room in the pipeline");

  // a wrapped phase step never gives more than half the sample rate
  a_freq_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (freq_ext <= half_hi && freq_ext >= half_lo))
    else $error("frequency beyond half the sample rate");

  // an empty input stage always takes a transfer
  a_first_cell: assert property (@(posedge clk) disable iff (rst)
    (!cv[0] && !rst) |-> !in_stall)
    else $error("empty input stage stalls");

endmodule

`default_nettype wire

>>> sim/pfd_checker.sv
// result checker for the polar fm discriminator: follows the rate register,
// predicts magnitude and frequency per input transfer and compares outputs; uses pfd_pkg
module pfd_checker
  import pfd_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_stall,
  input  pfd_in_t             in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  pfd_out_t            out_data,
  input  logic                cfg_we,
  input  logic [RateBits-1:0] cfg_data,
  output int                  fail_count,
  output int                  outstanding
);

  localparam int      Stages  = 16;
  localparam longint  InvGain = 64'd10188014;

  // atan(2^-i) as a fraction of a turn, 32-bit
  localparam logic [31:0] TurnStep [16] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861
  };

  logic [RateBits-1:0] rate;
  logic [15:0]         held_phase;
  pfd_out_t            pending_results[$];
  int                  errors;

  logic [15:0] cur_mag, cur_phase;
  pfd_out_t    want;

  // vectoring cordic: magnitude with gain corrected, phase in 1/65536 turn
  function automatic void polar_of(input pfd_in_t s, output logic [15:0] mag,
                                   output logic [15:0] ph);
    longint x, y, xs, ys;
    longint unsigned prod;
    logic [31:0] acc;
    x = longint'($signed(s.in_real));
    y = longint'($signed(s.in_imag));
    acc = '0;
    mag = '0;
    ph = '0;
    if (x != 0 || y != 0) begin
      x = x * 256;
      y = y * 256;
      if (x < 0) begin
        x = -x;
        y = -y;
        acc = 32'h8000_0000;
      end
      for (int i = 0; i < Stages; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          acc = acc + TurnStep[i];
        end else begin
          x = x - ys;
          y = y + xs;
          acc = acc - TurnStep[i];
        end
      end
      acc = acc + 32'h0000_8000;
      ph = acc[31:16];
      if (x < 0) x = 0;
      prod = ($unsigned(x) * InvGain + 64'h8000_0000) >> 32;
      mag = (prod > 64'd65535) ? 16'hFFFF : prod[15:0];
    end
  endfunction

  // wrapped phase step times rate, floor-shifted by the phase width
  function automatic logic [23:0] freq_of(input logic [15:0] ph, input logic [15:0] last,
                                          input logic [RateBits-1:0] r);
    logic [15:0] d;
    longint dp, f;
    d = ph - last;
    dp = $signed(d);
    f = (dp * longint'(r)) >>> 16;
    return f[23:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rate = RateReset;
      held_phase = '0;
      pending_results.delete();
      errors = 0;
      fail_count <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) rate = cfg_data;
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected transfer out: mag %0d freq %0d",
                     out_data.magnitude, out_data.freq_hz);
        end else begin
          want = pending_results.pop_front();
          if (out_data.magnitude !== want.magnitude || out_data.freq_hz !== want.freq_hz) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: mag exp %0d got %0d, freq exp %0d got %0d",
                       want.magnitude, out_data.magnitude, want.freq_hz, out_data.freq_hz);
          end
        end
      end
      if (in_valid && !in_stall) begin
        polar_of(in_data, cur_mag, cur_phase);
        want.magnitude = cur_mag;
        want.freq_hz = freq_of(cur_phase, held_phase, rate);
        held_phase = cur_phase;
        pending_results.push_back(want);
      end
      fail_count <= errors;
      outstanding <= pending_results.size();
    end
  end

endmodule

>>> sim/polar_fm_discriminator_core_test.sv
// testbench top for polar_fm_discriminator_core: clock, reset, samples, rate
// changes and random stalls; depends on pfd_pkg, the core and pfd_checker
module polar_fm_discriminator_core_test;
  import pfd_pkg::*;

  localparam real TwoPi = 6.283185307179586;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  pfd_in_t             in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  pfd_out_t            out_data;
  logic                cfg_we = 1'b0;
  logic [RateBits-1:0] cfg_data = '0;
  logic                gaps_on = 1'b1;
  int                  fail_count;
  int                  outstanding;

  real     tone_ang = 0.0;
  real     tone_step = 0.1;
  int      tone_amp = 20000;
  pfd_in_t last_sample = '0;

  polar_fm_discriminator_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  pfd_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= gaps_on && ($urandom_range(99) < 15);
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [15:0] corner_value();
    case ($urandom_range(4))
      0: return 16'h8000;
      1: return 16'hFFFF;
      2: return 16'h0000;
      3: return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  task automatic send_sample(input pfd_in_t s);
    while (gaps_on && $urandom_range(99) < 15) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= s;
    do @(posedge clk); while (in_stall);
  endtask

  // write only with the pipeline drained
  task automatic set_rate(input logic [RateBits-1:0] r);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= r;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic pick_sample(output pfd_in_t s);
    int kind;
    kind = $urandom_range(99);
    if (kind < 45) begin
      // rotating phasor, retuned now and then
      if ($urandom_range(39) == 0) begin
        tone_step = (real'($urandom_range(65535)) - 32768.0) * TwoPi / 65536.0;
        tone_amp = $urandom_range(32767);
      end
      tone_ang = tone_ang + tone_step;
      if (tone_ang > TwoPi) tone_ang = tone_ang - TwoPi;
      if (tone_ang < -TwoPi) tone_ang = tone_ang + TwoPi;
      s.in_real = 16'(int'(tone_amp * $cos(tone_ang)));
      s.in_imag = 16'(int'(tone_amp * $sin(tone_ang)));
    end else if (kind < 75) begin
      s = pfd_in_t'($urandom);
    end else if (kind < 85) begin
      s.in_real = corner_value();
      s.in_imag = corner_value();
    end else if (kind < 95) begin
      // half-turn step
      s.in_real = -last_sample.in_real;
      s.in_imag = -last_sample.in_imag;
    end else begin
      s.in_real = 16'(int'($urandom_range(8)) - 4);
      s.in_imag = 16'(int'($urandom_range(8)) - 4);
    end
    last_sample = s;
  endtask

  initial begin
    pfd_in_t             s;
    logic [RateBits-1:0] rates [8];
    pfd_in_t             directed [22];
    directed = '{
      '{16'h0000, 16'h0000}, '{16'h7FFF, 16'h0000}, '{16'h0000, 16'h7FFF},
      '{16'h8000, 16'h0000}, '{16'h0000, 16'h8000}, '{16'h8000, 16'h8000},
      '{16'h7FFF, 16'h7FFF}, '{16'h8000, 16'h7FFF}, '{16'h7FFF, 16'h8000},
      '{16'hFFFF, 16'h0000}, '{16'hFFFF, 16'hFFFF}, '{16'h0001, 16'h0000},
      '{16'h0000, 16'h0000}, '{16'h0064, 16'h0000}, '{16'hFF9C, 16'h0000},
      '{16'hFF9C, 16'hFFFF}, '{16'hFF9C, 16'h0000}, '{16'hFF9C, 16'h0001},
      '{16'h8000, 16'h0001}, '{16'h0001, 16'h0001}, '{16'h0000, 16'h0000},
      '{16'h5555, 16'hAAAA}
    };
    rates[0] = 24'hFFFFFF;
    rates[1] = 24'd1;
    rates[2] = 24'($urandom);
    rates[3] = 24'd0;
    rates[4] = 24'($urandom_range(200000, 1));
    rates[5] = 24'd2400000;
    rates[6] = 24'($urandom);
    rates[7] = 24'd48000;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_sample(directed[i]);

    for (int p = 0; p < 8; p++) begin
      set_rate(rates[p]);
      gaps_on <= (p != 4);
      for (int n = 0; n < 245; n++) begin
        pick_sample(s);
        send_sample(s);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/pfd_pkg.sv
design/pfd_cordic_cell.sv
design/pfd_gain_stage.sv
design/pfd_disc_stage.sv
design/polar_fm_discriminator_core.sv
sim/pfd_checker.sv
sim/polar_fm_discriminator_core_test.sv
